// ----- hdl/capture_pulse_width_and_wheel_speed_top_assert.svh -----
// Assertion macros shared by the capture block.
`ifndef CAPTURE_PULSE_WIDTH_AND_WHEEL_SPEED_TOP_ASSERT_SVH
`define CAPTURE_PULSE_WIDTH_AND_WHEEL_SPEED_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CPWWS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define CPWWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/cpwws_pkg.sv -----
`timescale 1ns / 1ps

package cpwws_pkg;

   // input item: one capture event
   typedef struct packed {
      logic [1:0]  capture_channel;
      logic [31:0] capture_stamp;
      logic        capture_fault;
   } req_item_type;

   // result item
   typedef struct packed {
      logic [1:0] result_channel;
      logic [7:0] result_value;
   } rsp_item_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   localparam int DIV_W     = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   localparam int WHEELS = 3;

   localparam logic [1:0]  RX_CHANNEL = 2'd0;
   localparam logic [31:0] PULSE_MIN  = 32'd100;
   localparam logic [31:0] PULSE_MAX  = 32'd200;
   localparam logic [7:0]  FORCE_MAX  = 8'd100;
   localparam logic [31:0] TIMER_HZ   = 32'd100000;

   // register indexes on the csr port
   localparam logic [1:0] CSR_HOLD_MASK = 2'd0;
   localparam logic [1:0] CSR_WHEEL0    = 2'd1;
   localparam logic [1:0] CSR_WHEEL1    = 2'd2;
   localparam logic [1:0] CSR_WHEEL2    = 2'd3;

endpackage

// ----- hdl/cpwws_divider.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module cpwws_divider
   import cpwws_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output div_status_type   status
);

   logic [DIV_W-1:0]     qd_ff, qd_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIV_W:0] trial;
   logic [DIV_W:0] diff;

   // one shift-subtract step
   always_comb begin
      trial   = {rem_ff, qd_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      qd_in   = qd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         qd_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // no borrow: divisor fits, take the difference
         if (!diff[DIV_W]) begin
            rem_in = diff[DIV_W-1:0];
            qd_in  = {qd_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            qd_in  = {qd_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      qd_ff  <= qd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = qd_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- hdl/capture_pulse_width_and_wheel_speed_top.sv -----
// Capture decoder: channel 0 captures alternate rising/falling receiver edges and each
// falling edge yields a brake force unless hold bit 0 stops an in-range width;
// channels 1..3 count wheel sensor captures in batches of SAMPLES_PER_BATCH and each
// closed batch without fault or hold yields revolutions per second. Items are taken
// only while the sequencer is idle. A receiver capture that gives a result passes
// through S_EMIT, which hands the result to the output register. A closing wheel
// capture runs three divisions in turn (mean period, speed, per revolution) on one
// bit-serial divider that produces one quotient bit per cycle. Each division has a
// start, 32 quotient bits and the handoff back to the sequencer; a zero mean period
// skips the other two divisions and yields zero. The output register holds a result
// while the next item is accepted. A result that finds the output register still full
// waits until it drains, and input stays blocked while it waits.
`timescale 1ns / 1ps
`include "capture_pulse_width_and_wheel_speed_top_assert.svh"

module capture_pulse_width_and_wheel_speed_top
   import cpwws_pkg::*;
#(
   parameter int SAMPLES_PER_BATCH = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   localparam int               CNT_W         = $clog2(SAMPLES_PER_BATCH);
   localparam logic [CNT_W-1:0] LAST_SAMPLE   = CNT_W'(SAMPLES_PER_BATCH - 1);
   localparam logic [DIV_W-1:0] BATCH_DIVISOR = DIV_W'(SAMPLES_PER_BATCH - 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DIVP = 5'b00010,
      S_DIVS = 5'b00100,
      S_DIVR = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [3:0]       hold_ff, hold_in;
   logic [7:0]       ppr_ff [0:WHEELS-1];
   logic [7:0]       ppr_in [0:WHEELS-1];
   logic [CNT_W-1:0] count_ff [0:WHEELS-1];
   logic [CNT_W-1:0] count_in [0:WHEELS-1];
   logic [31:0]      first_ff [0:WHEELS-1];
   logic [31:0]      first_in [0:WHEELS-1];
   logic [31:0]      start_ff, start_in;
   logic             awaiting_ff, awaiting_in;
   logic [1:0]       wheel_ff, wheel_in;
   logic [1:0]       res_chan_ff, res_chan_in;
   logic [7:0]       res_value_ff, res_value_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_data_ff, rsp_data_in;
   logic             div_start_ff, div_start_in;
   logic [DIV_W-1:0] div_dividend_ff, div_dividend_in;
   logic [DIV_W-1:0] div_divisor_ff, div_divisor_in;

   logic [DIV_W-1:0] div_quot;
   div_status_type   div_status;
   logic [31:0]      pulse_width;
   logic [1:0]       wheel_idx;

   cpwws_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend_ff),
      .divisor  (div_divisor_ff),
      .quotient (div_quot),
      .status   (div_status)
   );

   assign pulse_width = req_data.capture_stamp - start_ff;
   assign wheel_idx   = req_data.capture_channel - 2'd1;
   assign req_ready   = (state_ff == S_IDLE);

   // sequencer, batch counters and csr writes
   always_comb begin
      state_in        = state_ff;
      hold_in         = hold_ff;
      ppr_in          = ppr_ff;
      count_in        = count_ff;
      first_in        = first_ff;
      start_in        = start_ff;
      awaiting_in     = awaiting_ff;
      wheel_in        = wheel_ff;
      res_chan_in     = res_chan_ff;
      res_value_in    = res_value_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      div_start_in    = 1'b0;
      div_dividend_in = div_dividend_ff;
      div_divisor_in  = div_divisor_ff;

      // output register drains
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.capture_channel == RX_CHANNEL) begin
                  if (!awaiting_ff) begin
                     start_in    = req_data.capture_stamp;
                     awaiting_in = 1'b1;
                  end else begin
                     awaiting_in = 1'b0;
                     res_chan_in = RX_CHANNEL;
                     if (pulse_width < PULSE_MIN) begin
                        res_value_in = '0;
                        state_in     = S_EMIT;
                     end else if (pulse_width > PULSE_MAX) begin
                        res_value_in = FORCE_MAX;
                        state_in     = S_EMIT;
                     end else if (!hold_ff[0]) begin
                        // width is at most 200 here, so 8 bits carry it
                        res_value_in = pulse_width[7:0] - PULSE_MIN[7:0];
                        state_in     = S_EMIT;
                     end
                  end
               end else if (ppr_ff[wheel_idx] != 8'd0) begin
                  if (count_ff[wheel_idx] == '0) begin
                     first_in[wheel_idx] = req_data.capture_stamp;
                  end
                  if (count_ff[wheel_idx] == LAST_SAMPLE) begin
                     count_in[wheel_idx] = '0;
                     if (!req_data.capture_fault && !hold_ff[req_data.capture_channel]) begin
                        div_start_in    = 1'b1;
                        div_dividend_in = req_data.capture_stamp - first_ff[wheel_idx];
                        div_divisor_in  = BATCH_DIVISOR;
                        wheel_in        = wheel_idx;
                        res_chan_in     = req_data.capture_channel;
                        state_in        = S_DIVP;
                     end
                  end else begin
                     count_in[wheel_idx] = count_ff[wheel_idx] + 1'b1;
                  end
               end
            end
         end
         S_DIVP: begin
            if (div_status.done) begin
               if (div_quot == '0) begin
                  res_value_in = '0;
                  state_in     = S_EMIT;
               end else begin
                  div_start_in    = 1'b1;
                  div_dividend_in = TIMER_HZ;
                  div_divisor_in  = div_quot;
                  state_in        = S_DIVS;
               end
            end
         end
         S_DIVS: begin
            if (div_status.done) begin
               div_start_in    = 1'b1;
               div_dividend_in = div_quot;
               div_divisor_in  = DIV_W'(ppr_ff[wheel_ff]);
               state_in        = S_DIVR;
            end
         end
         S_DIVR: begin
            if (div_status.done) begin
               res_value_in = div_quot[7:0];
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.result_channel = res_chan_ff;
               rsp_data_in.result_value   = res_value_ff;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_HOLD_MASK: hold_in   = csr_wdata[3:0];
            CSR_WHEEL0:    ppr_in[0] = csr_wdata;
            CSR_WHEEL1:    ppr_in[1] = csr_wdata;
            CSR_WHEEL2:    ppr_in[2] = csr_wdata;
            default:       hold_in   = hold_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hold_ff      <= '0;
         start_ff     <= '0;
         awaiting_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         for (int i = 0; i < WHEELS; i++) begin
            ppr_ff[i]   <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         hold_ff      <= hold_in;
         start_ff     <= start_in;
         awaiting_ff  <= awaiting_in;
         rsp_valid_ff <= rsp_valid_in;
         div_start_ff <= div_start_in;
         ppr_ff       <= ppr_in;
         count_ff     <= count_in;
      end
      first_ff        <= first_in;
      wheel_ff        <= wheel_in;
      res_chan_ff     <= res_chan_in;
      res_value_ff    <= res_value_in;
      rsp_data_ff     <= rsp_data_in;
      div_dividend_ff <= div_dividend_in;
      div_divisor_ff  <= div_divisor_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `CPWWS_ASSERT_IMPL(a_div_start_free, clock, reset, div_start_ff, !div_status.busy, "divider restarted while busy")
   `CPWWS_ASSERT_IMPL(a_div_done_state, clock, reset, div_status.done, (state_ff == S_DIVP || state_ff == S_DIVS || state_ff == S_DIVR), "divider done outside a division state")
   `CPWWS_ASSERT_IMPL(a_force_range, clock, reset, rsp_valid_ff && rsp_data_ff.result_channel == RX_CHANNEL, rsp_data_ff.result_value <= FORCE_MAX, "brake force out of range")
   `CPWWS_ASSERT_NEXT(a_emit_loads, clock, reset, state_ff == S_EMIT && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && state_ff == S_IDLE, "result not loaded into output register")

endmodule
